/* hw/rtl/elfpc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// elfpc_pkg: shared constants for the echo level filter and pump control
// Field widths, register indexes and reset values, and the fixed-point
// constants of the echo-to-distance conversion.
// ----------------------------------------------------------------------------
package elfpc_pkg;

    localparam int WINDOW_LEN_DEF      = 10;
    localparam int ECHO_TIMEOUT_US_DEF = 7352;

    localparam int ECHO_W  = 13;
    localparam int LEVEL_W = 10;
    localparam int DIST_W  = 9;   // distance in cm, also divisor width
    localparam int USE_W   = 8;   // usable distances stay below 256
    localparam int MIN_W   = 4;
    localparam int LIM_W   = 8;
    localparam int CMP_W   = 8;

    // distance = echo * 34 / 1000 = echo * 17 / 500
    localparam int PROD_W     = 18;
    localparam int DIST_MUL_SHIFT = 4;   // 17 = 16 + 1
    localparam int DIST_DIV   = 500;
    localparam int DIST_ITERS = 9;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 10;

    localparam logic [CFG_ADDR_W-1:0] CFG_MOUNT_HEIGHT   = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_SAMPLE_LIMIT   = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_MIN_USABLE     = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_LEVEL_LIMIT    = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_RISE_DELTA     = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] CFG_PUMP_ON_LEVEL  = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] CFG_PUMP_OFF_LEVEL = 3'd6;

    localparam logic [LEVEL_W-1:0] RST_MOUNT_HEIGHT   = 10'd300;
    localparam logic [LIM_W-1:0]   RST_SAMPLE_LIMIT   = 8'd250;
    localparam logic [MIN_W-1:0]   RST_MIN_USABLE     = 4'd7;
    localparam logic [LEVEL_W-1:0] RST_LEVEL_LIMIT    = 10'd250;
    localparam logic [LEVEL_W-1:0] RST_RISE_DELTA     = 10'd10;
    localparam logic [LEVEL_W-1:0] RST_PUMP_ON_LEVEL  = 10'd100;
    localparam logic [LEVEL_W-1:0] RST_PUMP_OFF_LEVEL = 10'd80;

    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_CHECK  = 1'b1;

    typedef logic [1:0] t_kind;
    localparam t_kind KIND_NONE  = 2'd0;
    localparam t_kind KIND_FORCE = 2'd1;
    localparam t_kind KIND_AVG   = 2'd2;

endpackage

/* hw/rtl/echo_level_filter_pump_control.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// echo_level_filter_pump_control: echo-width level filter and pump request
// A check goes straight to the result; a sample runs the serial divider for
// the distance and, with a full window of enough usable entries, a second
// division for the average. One transaction is in work; the next is accepted
// in the cycle after the result registers; a held result stalls it at the output.
// Synchronous active-low reset clears fill, level, pump state; restores registers.
// ----------------------------------------------------------------------------
module echo_level_filter_pump_control
    import elfpc_pkg::*;
#(
    parameter int WINDOW_LEN      = WINDOW_LEN_DEF,
    parameter int ECHO_TIMEOUT_US = ECHO_TIMEOUT_US_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [15:0]           s_axis_tdata,  // echo_us[12:0]
    input  logic [1:0]            s_axis_tuser,  // op, timed_out
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [15:0]           m_axis_tdata   // level[9:0], level_changed,
                                                 // pump_on, pump_on_event,
                                                 // pump_off_event
);

    localparam int CNT_W  = $clog2(WINDOW_LEN + 1);
    localparam int SUM_W  = USE_W + CNT_W;
    localparam int ITER_W = $clog2(SUM_W + 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DIST = 3'd1;
    localparam logic [2:0] S_EVAL = 3'd2;
    localparam logic [2:0] S_AVG  = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;

    logic [2:0]         r_state;
    logic [LEVEL_W-1:0] r_mount_height;
    logic [LIM_W-1:0]   r_sample_limit;
    logic [MIN_W-1:0]   r_min_usable;
    logic [LEVEL_W-1:0] r_level_limit;
    logic [LEVEL_W-1:0] r_rise_delta;
    logic [LEVEL_W-1:0] r_pump_on_level;
    logic [LEVEL_W-1:0] r_pump_off_level;
    logic [LEVEL_W-1:0] r_level;
    logic [LEVEL_W-1:0] r_prev;
    logic               r_pump;
    logic               r_out_valid;
    logic [15:0]        r_out_data;
    logic               r_op;
    logic               r_tmo;
    logic [ECHO_W-1:0]  r_echo;
    t_kind              r_kind;
    logic [SUM_W-1:0]   r_avg;

    logic               w_accept;
    logic               w_out_free;
    logic [ECHO_W-1:0]  w_echo;
    logic [PROD_W-1:0]  w_prod;
    logic               w_div_start;
    logic [ITER_W-1:0]  w_iters;
    logic [DIST_W-1:0]  w_rem_init;
    logic [SUM_W-1:0]   w_dividend;
    logic [DIST_W-1:0]  w_divisor;
    logic               w_div_done;
    logic [SUM_W-1:0]   w_quot;
    logic               w_push;
    logic [DIST_W-1:0]  w_dist;
    logic               w_ok;
    logic [SUM_W-1:0]   w_sum;
    logic [CNT_W-1:0]   w_count;
    logic               w_full;
    logic               w_avg_fail;
    logic               w_avg_go;

    logic [LEVEL_W-1:0] n_level;
    logic               n_changed;
    logic               n_pump;
    logic               n_on_ev;
    logic               n_off_ev;
    logic [LEVEL_W-1:0] w_cand;
    logic [LEVEL_W:0]   w_rise;
    logic               w_rise_ok;

    assign w_accept   = s_axis_tvalid && s_axis_tready;
    assign w_out_free = !r_out_valid || m_axis_tready;
    assign w_echo     = s_axis_tdata[ECHO_W-1:0];
    assign w_prod     = (PROD_W'(w_echo) << DIST_MUL_SHIFT) + PROD_W'(w_echo);

    assign w_avg_fail = (w_count == '0) || (CMP_W'(w_count) < CMP_W'(r_min_usable));
    assign w_avg_go   = (r_state == S_EVAL) && w_full && !w_avg_fail;

    assign w_div_start = ((r_state == S_IDLE) && w_accept && (s_axis_tuser[0] == OP_SAMPLE))
                         || w_avg_go;

    always_comb begin
        if (r_state == S_IDLE) begin
            w_iters    = ITER_W'(DIST_ITERS);
            w_rem_init = w_prod[PROD_W-1:DIST_W];
            w_dividend = {w_prod[DIST_W-1:0], {(SUM_W-DIST_W){1'b0}}};
            w_divisor  = DIST_W'(DIST_DIV);
        end else begin
            w_iters    = ITER_W'(SUM_W);
            w_rem_init = '0;
            w_dividend = w_sum;
            w_divisor  = DIST_W'(w_count);
        end
    end

    elfpc_serial_div #(
        .DVD_W  (SUM_W),
        .DVS_W  (DIST_W),
        .ITER_W (ITER_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_iters    (w_iters),
        .i_rem_init (w_rem_init),
        .i_dividend (w_dividend),
        .i_divisor  (w_divisor),
        .o_done     (w_div_done),
        .o_quotient (w_quot)
    );

    assign w_dist = w_quot[DIST_W-1:0];
    assign w_ok   = !r_tmo && (r_echo < ECHO_W'(ECHO_TIMEOUT_US))
                    && (w_dist < {1'b0, r_sample_limit});
    assign w_push = (r_state == S_DIST) && w_div_done;

    elfpc_window #(
        .WINDOW_LEN (WINDOW_LEN),
        .CNT_W      (CNT_W),
        .SUM_W      (SUM_W)
    ) u_window (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_dist  (w_dist),
        .i_ok    (w_ok),
        .o_sum   (w_sum),
        .o_count (w_count),
        .o_full  (w_full)
    );

    always_comb begin
        n_level   = r_level;
        n_changed = 1'b0;
        n_pump    = r_pump;
        n_on_ev   = 1'b0;
        n_off_ev  = 1'b0;
        w_cand    = r_mount_height - r_avg[LEVEL_W-1:0];
        w_rise    = {1'b0, r_level} - {1'b0, r_prev};
        w_rise_ok = !w_rise[LEVEL_W] && (w_rise[LEVEL_W-1:0] >= r_rise_delta);
        if (r_op == OP_SAMPLE) begin
            if (r_kind == KIND_FORCE) begin
                n_level   = r_mount_height;
                n_changed = 1'b1;
            end else if (r_kind == KIND_AVG) begin
                if ((r_avg <= SUM_W'(r_mount_height)) && (w_cand < r_level_limit)
                    && (w_cand != r_level)) begin
                    n_level   = w_cand;
                    n_changed = 1'b1;
                end
            end
        end else begin
            if (w_rise_ok && (r_level > r_pump_on_level) && (r_level != r_mount_height)
                && !n_pump) begin
                n_pump  = 1'b1;
                n_on_ev = 1'b1;
            end
            if ((r_level < r_pump_off_level) && n_pump) begin
                n_pump   = 1'b0;
                n_off_ev = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state          <= S_IDLE;
            r_mount_height   <= RST_MOUNT_HEIGHT;
            r_sample_limit   <= RST_SAMPLE_LIMIT;
            r_min_usable     <= RST_MIN_USABLE;
            r_level_limit    <= RST_LEVEL_LIMIT;
            r_rise_delta     <= RST_RISE_DELTA;
            r_pump_on_level  <= RST_PUMP_ON_LEVEL;
            r_pump_off_level <= RST_PUMP_OFF_LEVEL;
            r_level          <= '0;
            r_prev           <= '0;
            r_pump           <= 1'b0;
            r_out_valid      <= 1'b0;
            r_kind           <= KIND_NONE;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_MOUNT_HEIGHT:   r_mount_height   <= i_cfg_wdata;
                    CFG_SAMPLE_LIMIT:   r_sample_limit   <= i_cfg_wdata[LIM_W-1:0];
                    CFG_MIN_USABLE:     r_min_usable     <= i_cfg_wdata[MIN_W-1:0];
                    CFG_LEVEL_LIMIT:    r_level_limit    <= i_cfg_wdata;
                    CFG_RISE_DELTA:     r_rise_delta     <= i_cfg_wdata;
                    CFG_PUMP_ON_LEVEL:  r_pump_on_level  <= i_cfg_wdata;
                    CFG_PUMP_OFF_LEVEL: r_pump_off_level <= i_cfg_wdata;
                    default: ;
                endcase
            end

            if (m_axis_tready && !((r_state == S_FIN) && w_out_free)) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_kind  <= KIND_NONE;
                        r_state <= (s_axis_tuser[0] == OP_CHECK) ? S_FIN : S_DIST;
                    end
                end
                S_DIST: begin
                    if (w_div_done) begin
                        r_state <= S_EVAL;
                    end
                end
                S_EVAL: begin
                    if (!w_full) begin
                        r_kind  <= KIND_NONE;
                        r_state <= S_FIN;
                    end else if (w_avg_fail) begin
                        r_kind  <= KIND_FORCE;
                        r_state <= S_FIN;
                    end else begin
                        r_state <= S_AVG;
                    end
                end
                S_AVG: begin
                    if (w_div_done) begin
                        r_kind  <= KIND_AVG;
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (w_out_free) begin
                        r_level     <= n_level;
                        r_pump      <= n_pump;
                        if (r_op == OP_CHECK) begin
                            r_prev <= r_level;
                        end
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_IDLE) && w_accept) begin
            r_op   <= s_axis_tuser[0];
            r_tmo  <= s_axis_tuser[1];
            r_echo <= w_echo;
        end
        if ((r_state == S_AVG) && w_div_done) begin
            r_avg <= w_quot;
        end
        if ((r_state == S_FIN) && w_out_free) begin
            r_out_data <= {2'b00, n_off_ev, n_on_ev, n_pump, n_changed, n_level};
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

/* hw/rtl/elfpc_serial_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// elfpc_serial_div: bit-serial restoring divider
// One quotient bit per cycle; dividend bits enter MSB first from a shift
// register that collects the quotient at its low end.
// ----------------------------------------------------------------------------
module elfpc_serial_div #(
    parameter int DVD_W  = 12,
    parameter int DVS_W  = 9,
    parameter int ITER_W = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [ITER_W-1:0] i_iters,
    input  logic [DVS_W-1:0]  i_rem_init,
    input  logic [DVD_W-1:0]  i_dividend,
    input  logic [DVS_W-1:0]  i_divisor,
    output logic              o_done,
    output logic [DVD_W-1:0]  o_quotient
);

    logic              r_run;
    logic              r_done;
    logic [ITER_W-1:0] r_cnt;
    logic [DVS_W-1:0]  r_rem;
    logic [DVD_W-1:0]  r_shift;
    logic [DVS_W-1:0]  r_divisor;

    logic [DVS_W:0] w_trial;
    logic [DVS_W:0] w_diff;
    logic           w_ge;

    always_comb begin
        w_trial = {r_rem, r_shift[DVD_W-1]};
        w_diff  = w_trial - {1'b0, r_divisor};
        w_ge    = (w_trial >= {1'b0, r_divisor});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
                r_cnt <= i_iters;
            end else if (r_run) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == ITER_W'(1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem     <= i_rem_init;
            r_shift   <= i_dividend;
            r_divisor <= i_divisor;
        end else if (r_run) begin
            r_rem   <= w_ge ? w_diff[DVS_W-1:0] : w_trial[DVS_W-1:0];
            r_shift <= {r_shift[DVD_W-2:0], w_ge};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_shift;

endmodule

/* hw/rtl/elfpc_window.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// elfpc_window: sliding window of distance samples
// Shift line of distances with usable flags, a running sum and count of the
// usable entries, and a saturating fill count.
// ----------------------------------------------------------------------------
module elfpc_window
    import elfpc_pkg::*;
#(
    parameter int WINDOW_LEN = WINDOW_LEN_DEF,
    parameter int CNT_W      = $clog2(WINDOW_LEN + 1),
    parameter int SUM_W      = USE_W + CNT_W
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [DIST_W-1:0] i_dist,
    input  logic              i_ok,
    output logic [SUM_W-1:0]  o_sum,
    output logic [CNT_W-1:0]  o_count,
    output logic              o_full
);

    logic [DIST_W-1:0] r_dist [WINDOW_LEN];
    logic              r_ok   [WINDOW_LEN];
    logic [CNT_W-1:0]  r_fill;
    logic [SUM_W-1:0]  r_sum;
    logic [CNT_W-1:0]  r_count;

    logic              w_full;
    logic              w_drop_ok;
    logic [SUM_W-1:0]  n_sum;
    logic [CNT_W-1:0]  n_count;

    always_comb begin
        w_full    = (r_fill == CNT_W'(WINDOW_LEN));
        w_drop_ok = w_full && r_ok[0];
        n_sum     = r_sum;
        n_count   = r_count;
        if (i_ok) begin
            n_sum   = n_sum + SUM_W'(i_dist);
            n_count = n_count + 1'b1;
        end
        if (w_drop_ok) begin
            n_sum   = n_sum - SUM_W'(r_dist[0]);
            n_count = n_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill  <= '0;
            r_sum   <= '0;
            r_count <= '0;
        end else if (i_push) begin
            r_sum   <= n_sum;
            r_count <= n_count;
            if (!w_full) begin
                r_fill <= r_fill + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            for (int i = 0; i < WINDOW_LEN - 1; i++) begin
                r_dist[i] <= r_dist[i+1];
                r_ok[i]   <= r_ok[i+1];
            end
            r_dist[WINDOW_LEN-1] <= i_dist;
            r_ok[WINDOW_LEN-1]   <= i_ok;
        end
    end

    assign o_sum   = r_sum;
    assign o_count = r_count;
    assign o_full  = w_full;

endmodule
